@@ sv/http_request_tokenizer_top_defines.svh @@
// Assertion macros for the checker file of the request tokenizer.
`ifndef HTTP_REQUEST_TOKENIZER_TOP_DEFINES_SVH
`define HTTP_REQUEST_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hrt_pkg.sv @@
// Types, codes and constants shared by the request tokenizer modules.
`timescale 1ns / 1ps

package hrt_pkg;

    localparam logic [3:0] MAX_HEADERS = 4'd10;
    localparam logic [7:0] MAX_FIELD   = 8'd255;
    localparam logic [9:0] MAX_REQUEST = 10'd1023;

    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [9:0] RST_REQUEST_LIMIT = 10'd1023;
    localparam logic [7:0] RST_METHOD_LIMIT  = 8'd15;
    localparam logic [7:0] RST_PATH_LIMIT    = 8'd255;
    localparam logic [7:0] RST_VERSION_LIMIT = 8'd15;
    localparam logic [7:0] RST_KEY_LIMIT     = 8'd63;
    localparam logic [7:0] RST_VALUE_LIMIT   = 8'd255;
    localparam logic [3:0] RST_HEADER_LIMIT  = 4'd10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_REQUEST_LIMIT = 3'd0,
        REG_METHOD_LIMIT  = 3'd1,
        REG_PATH_LIMIT    = 3'd2,
        REG_VERSION_LIMIT = 3'd3,
        REG_KEY_LIMIT     = 3'd4,
        REG_VALUE_LIMIT   = 3'd5,
        REG_HEADER_LIMIT  = 3'd6
    } hrt_reg_t;

    typedef enum logic [2:0] {
        KIND_METHOD  = 3'd0,
        KIND_PATH    = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_KEY     = 3'd3,
        KIND_VALUE   = 3'd4,
        KIND_DISCARD = 3'd5,
        KIND_END     = 3'd6
    } hrt_kind_t;

    typedef enum logic [2:0] {
        PH_LEAD       = 3'd0,
        PH_GAP        = 3'd1,
        PH_TOKEN      = 3'd2,
        PH_LINE_START = 3'd3,
        PH_KEY        = 3'd4,
        PH_VAL_LEAD   = 3'd5,
        PH_VALUE      = 3'd6
    } hrt_phase_t;

    typedef struct packed {
        hrt_kind_t   kind;
        logic [3:0]  slot;
        logic [7:0]  position;
        logic [7:0]  char_out;
        logic [3:0]  headers_kept;
        logic        last_of_run;
    } hrt_res_t;

    // All results caused by one input item, packed from index 0.
    typedef struct packed {
        logic [1:0]          count;
        hrt_res_t [2:0]      res;
    } hrt_bundle_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } hrt_q_stat_t;

endpackage

@@ sv/hrt_ifs.sv @@
// Channel interfaces of the request tokenizer: input bytes, results, register writes.
`timescale 1ns / 1ps

interface hrt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_request;

    modport source (output valid, output in_byte, output end_of_request, input ready);
    modport sink   (input valid, input in_byte, input end_of_request, output ready);
endinterface

interface hrt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] slot;
    logic [7:0] position;
    logic [7:0] char_out;
    logic [3:0] headers_kept;
    logic       last_of_run;

    modport source (output valid, output kind, output slot, output position,
                    output char_out, output headers_kept, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input slot, input position,
                    input char_out, input headers_kept, input last_of_run,
                    output ready);
endinterface

interface hrt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [9:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/hrt_front.sv @@
// Front end: limit registers, parser state and per-byte result bundle.
`timescale 1ns / 1ps

module hrt_front
    import hrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hrt_in_if.sink       in_ch,
    hrt_cfg_if.sink      cfg,
    input  hrt_q_stat_t  q_stat,
    output logic         push,
    output hrt_bundle_t  push_data
);

    logic [9:0] request_lim_reg;
    logic [7:0] method_lim_reg;
    logic [7:0] path_lim_reg;
    logic [7:0] version_lim_reg;
    logic [7:0] key_lim_reg;
    logic [7:0] value_lim_reg;
    logic [3:0] header_lim_reg;

    hrt_phase_t phase_reg, phase_next;
    logic [1:0] token_reg, token_next;
    logic [7:0] fpos_reg, fpos_next;
    logic [9:0] bytes_reg, bytes_next;
    logic [3:0] hdr_reg, hdr_next;
    logic       ended_reg, ended_next;

    logic       accept;
    logic [9:0] rlim;
    logic [3:0] hlim;
    logic [7:0] klim;
    logic [7:0] vlim;
    logic [7:0] tlim;
    logic [1:0] tok_sel;
    logic [7:0] b;

    logic       e_valid, d_valid, q_valid;
    hrt_res_t   e_res, d_res, q_res;
    logic [1:0] cnt;
    logic [1:0] cnt_m1;

    function automatic hrt_res_t make_res(hrt_kind_t k, logic [3:0] s, logic [7:0] p,
                                          logic [7:0] c, logic [3:0] h);
        hrt_res_t r;
        r.kind         = k;
        r.slot         = s;
        r.position     = p;
        r.char_out     = c;
        r.headers_kept = h;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.in_byte;

    assign rlim = (request_lim_reg < MAX_REQUEST) ? request_lim_reg : MAX_REQUEST;
    assign hlim = (header_lim_reg < MAX_HEADERS) ? header_lim_reg : MAX_HEADERS;
    assign klim = (key_lim_reg < MAX_FIELD) ? key_lim_reg : MAX_FIELD;
    assign vlim = (value_lim_reg < MAX_FIELD) ? value_lim_reg : MAX_FIELD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_lim_reg <= RST_REQUEST_LIMIT;
            method_lim_reg  <= RST_METHOD_LIMIT;
            path_lim_reg    <= RST_PATH_LIMIT;
            version_lim_reg <= RST_VERSION_LIMIT;
            key_lim_reg     <= RST_KEY_LIMIT;
            value_lim_reg   <= RST_VALUE_LIMIT;
            header_lim_reg  <= RST_HEADER_LIMIT;
        end
        else if (cfg.valid)
        begin
            case (hrt_reg_t'(cfg.index))
                REG_REQUEST_LIMIT: request_lim_reg <= cfg.data;
                REG_METHOD_LIMIT:  method_lim_reg  <= cfg.data[7:0];
                REG_PATH_LIMIT:    path_lim_reg    <= cfg.data[7:0];
                REG_VERSION_LIMIT: version_lim_reg <= cfg.data[7:0];
                REG_KEY_LIMIT:     key_lim_reg     <= cfg.data[7:0];
                REG_VALUE_LIMIT:   value_lim_reg   <= cfg.data[7:0];
                REG_HEADER_LIMIT:  header_lim_reg  <= cfg.data[3:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            token_reg <= 2'd0;
            fpos_reg  <= 8'd0;
            bytes_reg <= 10'd0;
            hdr_reg   <= 4'd0;
            ended_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            token_reg <= token_next;
            fpos_reg  <= fpos_next;
            bytes_reg <= bytes_next;
            hdr_reg   <= hdr_next;
            ended_reg <= ended_next;
        end
    end

    // Token this byte belongs to; a fresh first line starts at the method.
    assign tok_sel = (phase_reg == PH_LEAD) ? 2'd0 : token_reg;

    always_comb
    begin
        case (tok_sel)
            2'd0:    tlim = method_lim_reg;
            2'd1:    tlim = path_lim_reg;
            default: tlim = version_lim_reg;
        endcase
        if (tlim > MAX_FIELD)
        begin
            tlim = MAX_FIELD;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        token_next = token_reg;
        fpos_next  = fpos_reg;
        bytes_next = bytes_reg;
        hdr_next   = hdr_reg;
        ended_next = ended_reg;
        e_valid    = 1'b0;
        d_valid    = 1'b0;
        q_valid    = 1'b0;
        e_res      = '0;
        d_res      = '0;
        q_res      = '0;

        if (!ended_reg && bytes_reg < rlim)
        begin
            if (b == CH_NUL || b == CH_CR || b == CH_LF)
            begin
                // Line break or end of text: close the open line.
                if (b == CH_NUL || phase_reg != PH_LEAD)
                begin
                    if (phase_reg == PH_KEY)
                    begin
                        e_valid = 1'b1;
                        e_res   = make_res(KIND_DISCARD, hdr_reg, 8'd0, 8'd0, 4'd0);
                    end
                    else if (phase_reg == PH_VAL_LEAD || phase_reg == PH_VALUE)
                    begin
                        hdr_next = hdr_reg + 4'd1;
                    end
                    if (phase_reg != PH_LEAD)
                    begin
                        phase_next = PH_LINE_START;
                    end
                    fpos_next = 8'd0;
                end
                if (b == CH_NUL)
                begin
                    ended_next = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_LEAD, PH_GAP:
                    begin
                        if (phase_reg == PH_LEAD)
                        begin
                            token_next = 2'd0;
                        end
                        if (b == CH_SPACE)
                        begin
                            phase_next = PH_GAP;
                        end
                        else
                        begin
                            phase_next = PH_TOKEN;
                            if (tok_sel != 2'd3 && tlim != 8'd0)
                            begin
                                e_valid = 1'b1;
                                e_res   = make_res(hrt_kind_t'({1'b0, tok_sel}), 4'd0,
                                                   8'd0, b, 4'd0);
                            end
                            fpos_next = 8'd1;
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (b == CH_SPACE)
                        begin
                            if (token_reg != 2'd3)
                            begin
                                token_next = token_reg + 2'd1;
                            end
                            phase_next = PH_GAP;
                            fpos_next  = 8'd0;
                        end
                        else
                        begin
                            if (token_reg != 2'd3 && fpos_reg < tlim)
                            begin
                                e_valid = 1'b1;
                                e_res   = make_res(hrt_kind_t'({1'b0, token_reg}), 4'd0,
                                                   fpos_reg, b, 4'd0);
                            end
                            if (fpos_reg != 8'hFF)
                            begin
                                fpos_next = fpos_reg + 8'd1;
                            end
                        end
                    end
                    PH_LINE_START:
                    begin
                        // Ignore the whole line once all header slots are used.
                        if (hdr_reg < hlim)
                        begin
                            fpos_next = 8'd0;
                            if (b == CH_COLON)
                            begin
                                phase_next = PH_VAL_LEAD;
                            end
                            else
                            begin
                                phase_next = PH_KEY;
                                if (klim != 8'd0)
                                begin
                                    e_valid = 1'b1;
                                    e_res   = make_res(KIND_KEY, hdr_reg, 8'd0, b, 4'd0);
                                end
                                fpos_next = 8'd1;
                            end
                        end
                    end
                    PH_KEY:
                    begin
                        if (b == CH_COLON && fpos_reg != 8'd0)
                        begin
                            phase_next = PH_VAL_LEAD;
                            fpos_next  = 8'd0;
                        end
                        else
                        begin
                            if (fpos_reg < klim)
                            begin
                                e_valid = 1'b1;
                                e_res   = make_res(KIND_KEY, hdr_reg, fpos_reg, b, 4'd0);
                            end
                            if (fpos_reg != 8'hFF)
                            begin
                                fpos_next = fpos_reg + 8'd1;
                            end
                        end
                    end
                    PH_VAL_LEAD:
                    begin
                        // Drop leading spaces of the value.
                        if (b != CH_SPACE)
                        begin
                            phase_next = PH_VALUE;
                            if (vlim != 8'd0)
                            begin
                                e_valid = 1'b1;
                                e_res   = make_res(KIND_VALUE, hdr_reg, 8'd0, b, 4'd0);
                            end
                            fpos_next = 8'd1;
                        end
                    end
                    default:
                    begin
                        if (fpos_reg < vlim)
                        begin
                            e_valid = 1'b1;
                            e_res   = make_res(KIND_VALUE, hdr_reg, fpos_reg, b, 4'd0);
                        end
                        if (fpos_reg != 8'hFF)
                        begin
                            fpos_next = fpos_reg + 8'd1;
                        end
                    end
                endcase
            end

            // Count the byte; close the text when the byte budget is used up.
            if (!ended_next)
            begin
                bytes_next = bytes_reg + 10'd1;
                if (bytes_next >= rlim)
                begin
                    if (phase_next == PH_KEY)
                    begin
                        d_valid = 1'b1;
                        d_res   = make_res(KIND_DISCARD, hdr_next, 8'd0, 8'd0, 4'd0);
                    end
                    else if (phase_next == PH_VAL_LEAD || phase_next == PH_VALUE)
                    begin
                        hdr_next = hdr_next + 4'd1;
                    end
                    if (phase_next != PH_LEAD)
                    begin
                        phase_next = PH_LINE_START;
                    end
                    fpos_next  = 8'd0;
                    ended_next = 1'b1;
                end
            end
        end

        if (in_ch.end_of_request)
        begin
            if (!ended_next)
            begin
                if (phase_next == PH_KEY)
                begin
                    d_valid = 1'b1;
                    d_res   = make_res(KIND_DISCARD, hdr_next, 8'd0, 8'd0, 4'd0);
                end
                else if (phase_next == PH_VAL_LEAD || phase_next == PH_VALUE)
                begin
                    hdr_next = hdr_next + 4'd1;
                end
            end
            q_valid    = 1'b1;
            q_res      = make_res(KIND_END, 4'd0, 8'd0, 8'd0, hdr_next);
            phase_next = PH_LEAD;
            token_next = 2'd0;
            fpos_next  = 8'd0;
            bytes_next = 10'd0;
            hdr_next   = 4'd0;
            ended_next = 1'b0;
        end
    end

    // Pack the results in order and mark the final one.
    always_comb
    begin
        push_data = '0;
        cnt       = 2'd0;
        if (e_valid)
        begin
            push_data.res[cnt] = e_res;
            cnt                = cnt + 2'd1;
        end
        if (d_valid)
        begin
            push_data.res[cnt] = d_res;
            cnt                = cnt + 2'd1;
        end
        if (q_valid)
        begin
            push_data.res[cnt] = q_res;
            cnt                = cnt + 2'd1;
        end
        cnt_m1 = cnt - 2'd1;
        if (cnt != 2'd0)
        begin
            push_data.res[cnt_m1].last_of_run = 1'b1;
        end
        push_data.count = cnt;
    end

    assign push = accept && (cnt != 2'd0);

endmodule

@@ sv/hrt_queue.sv @@
// Bundle queue between the front end and the result serializer.
`timescale 1ns / 1ps

module hrt_queue
    import hrt_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  hrt_bundle_t  push_data,
    input  logic         pop,
    output hrt_bundle_t  head,
    output hrt_q_stat_t  q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrt_bundle_t        slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == CNT_W'(DEPTH));
    assign head             = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/hrt_back.sv @@
// Back end: walks each queued bundle and drives the result register.
`timescale 1ns / 1ps

module hrt_back
    import hrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  hrt_bundle_t  head,
    input  hrt_q_stat_t  q_stat,
    output logic         pop,
    hrt_out_if.source    out_ch
);

    logic       out_valid_reg, out_valid_next;
    hrt_res_t   out_res_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       at_last;

    assign load    = q_stat.not_empty && (!out_valid_reg || out_ch.ready);
    assign at_last = (idx_reg == head.count - 2'd1);
    assign pop     = load && at_last;

    always_comb
    begin
        out_valid_next = load || (out_valid_reg && !out_ch.ready);
        idx_next       = idx_reg;
        if (load)
        begin
            idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= head.res[idx_reg];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_res_reg.kind;
    assign out_ch.slot         = out_res_reg.slot;
    assign out_ch.position     = out_res_reg.position;
    assign out_ch.char_out     = out_res_reg.char_out;
    assign out_ch.headers_kept = out_res_reg.headers_kept;
    assign out_ch.last_of_run  = out_res_reg.last_of_run;

endmodule

@@ sv/http_request_tokenizer_top.sv @@
// Streaming tokenizer for the request line and header lines of a request.
// Channels: in_ch takes one request byte per item with an end_of_request flag;
// out_ch gives tagged characters (method, path, version, key, value), discard
// marks for header lines without a colon, and a request end item carrying the
// header count; cfg writes the seven limit registers by index, always ready.
// Each input item yields zero to three results; last_of_run flags the final
// one of an item. Results pass the bundle queue and the result register
// before out_ch. Throughput: one item per cycle while each item yields at
// most one result and out_ch is ready; an item with more results sends
// them one at a time through the single result register on out_ch.
// A bundle queue sits between the parser and the serializer, so bytes keep
// flowing while a downstream stall lasts, until the queue fills; then ready
// on in_ch drops and held results stay stable on out_ch.
// Reset: limits return to their defaults, parser state to waiting for the
// first line, queue and output empty. No clearing pass is needed.
`timescale 1ns / 1ps

module http_request_tokenizer_top
    import hrt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    hrt_in_if.sink    in_ch,
    hrt_out_if.source out_ch,
    hrt_cfg_if.sink   cfg
);

    // Bundles from the parser to the serializer.
    logic         push;
    hrt_bundle_t  push_data;
    logic         pop;
    hrt_bundle_t  head;
    hrt_q_stat_t  q_stat;

    // Parse each accepted byte and push its results as one bundle.
    hrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // Hold bundles so a stalled receiver does not stall the parser at once.
    hrt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // Send the results of the head bundle one per cycle while out_ch is ready.
    hrt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

@@ sv/hrt_chk.sv @@
// Port-level checks of the request tokenizer, bound to the top level.
`timescale 1ns / 1ps
`include "http_request_tokenizer_top_defines.svh"

module hrt_chk
    import hrt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_kind,
    input logic [7:0] out_position,
    input logic [7:0] out_char,
    input logic       out_last
);

    `HRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_char) && $stable(out_position), "result changed while stalled")
    `HRT_ASSERT_NEXT(a_run_goes_on, out_valid && out_ready && !out_last, out_valid, "results of one item were split by a gap")
    `HRT_ASSERT_SAME(a_end_is_last, out_valid && out_kind == KIND_END, out_last, "request end is not the final result of its item")
    `HRT_ASSERT_SAME(a_quiet_after_reset, !$past(rst_n), !out_valid, "result shown right after reset")

endmodule

bind http_request_tokenizer_top hrt_chk u_hrt_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.kind),
    .out_position (out_ch.position),
    .out_char     (out_ch.char_out),
    .out_last     (out_ch.last_of_run)
);

@@ bench/testbench.sv @@
// Self-checking bench for http_request_tokenizer_top: request bytes in, tagged characters out.
`timescale 1ns / 1ps

module testbench;
    import hrt_pkg::*;

    // Generous bound. The slowest legal run is about 430 bytes, each with up to
    // three results and random stalls, plus one long receiver hold-off.
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_flag;
    } req_byte_t;

    logic clk;
    logic rst_n;

    hrt_in_if  in_ch();
    hrt_out_if out_ch();
    hrt_cfg_if cfg_ch();

    http_request_tokenizer_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Bytes waiting for the driver, the request under construction, and the
    // tagged characters the tokenizer owes us, oldest first.
    req_byte_t pending_bytes[$];
    req_byte_t req_buf[$];
    hrt_res_t  expected_chars[$];
    hrt_res_t  step_chars[$];

    int unsigned bytes_queued;
    int unsigned bytes_accepted;
    int unsigned requests_done;
    int unsigned chars_checked;
    int unsigned settings_used;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned gap_odds;      // 0: no idling, else 1 in gap_odds chance per cycle
    int unsigned hold_cycles;   // long receiver hold-off, counted down below

    // ------------------------------------------------------------------
    // Tokenizer prediction: private copy of the limits and the parse state.
    // ------------------------------------------------------------------
    logic [9:0] lim_request;
    logic [7:0] lim_method;
    logic [7:0] lim_path;
    logic [7:0] lim_version;
    logic [7:0] lim_key;
    logic [7:0] lim_value;
    logic [3:0] lim_headers;

    hrt_phase_t parse_phase;
    logic [1:0] token_idx;
    logic [7:0] field_pos;
    logic [9:0] bytes_examined;
    logic [3:0] header_count;
    logic       text_done;

    function automatic void clear_parse();
        parse_phase    = PH_LEAD;
        token_idx      = '0;
        field_pos      = '0;
        bytes_examined = '0;
        header_count   = '0;
        text_done      = 1'b0;
    endfunction

    function automatic void add_char(hrt_kind_t k, logic [3:0] s, logic [7:0] p,
                                     logic [7:0] c, logic [3:0] n);
        hrt_res_t r;
        r.kind         = k;
        r.slot         = s;
        r.position     = p;
        r.char_out     = c;
        r.headers_kept = n;
        r.last_of_run  = 1'b0;
        step_chars.push_back(r);
    endfunction

    // Position saturates at the top of its 8-bit range.
    function automatic void advance_pos();
        if (field_pos != 8'hFF)
            field_pos = field_pos + 8'd1;
    endfunction

    function automatic logic [3:0] header_cap();
        return (lim_headers < MAX_HEADERS) ? lim_headers : MAX_HEADERS;
    endfunction

    function automatic void token_char(logic [7:0] c);
        logic [7:0] cap;
        cap = (token_idx == 2'd0) ? lim_method :
              (token_idx == 2'd1) ? lim_path : lim_version;
        if (token_idx < 2'd3 && field_pos < cap)
            add_char(hrt_kind_t'({1'b0, token_idx}), 4'd0, field_pos, c, 4'd0);
        advance_pos();
    endfunction

    function automatic void key_char(logic [7:0] c);
        if (field_pos < lim_key)
            add_char(KIND_KEY, header_count, field_pos, c, 4'd0);
        advance_pos();
    endfunction

    function automatic void value_char(logic [7:0] c);
        if (field_pos < lim_value)
            add_char(KIND_VALUE, header_count, field_pos, c, 4'd0);
        advance_pos();
    endfunction

    // Close the open line: a pending key turns into a discard, a seen colon
    // counts the header.
    function automatic void close_line();
        if (parse_phase == PH_KEY)
            add_char(KIND_DISCARD, header_count, 8'd0, 8'd0, 4'd0);
        else if (parse_phase == PH_VAL_LEAD || parse_phase == PH_VALUE)
            header_count = header_count + 4'd1;
        if (parse_phase != PH_LEAD)
            parse_phase = PH_LINE_START;
        field_pos = '0;
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        if (c == CH_NUL)
        begin
            close_line();
            text_done = 1'b1;
            return;
        end
        if (c == CH_CR || c == CH_LF)
        begin
            if (parse_phase != PH_LEAD)
                close_line();
            return;
        end
        case (parse_phase)
            PH_LEAD, PH_GAP:
            begin
                if (parse_phase == PH_LEAD)
                    token_idx = '0;
                if (c == CH_SPACE)
                    parse_phase = PH_GAP;
                else
                begin
                    parse_phase = PH_TOKEN;
                    field_pos   = '0;
                    token_char(c);
                end
            end
            PH_TOKEN:
            begin
                if (c == CH_SPACE)
                begin
                    if (token_idx < 2'd3)
                        token_idx = token_idx + 2'd1;
                    parse_phase = PH_GAP;
                    field_pos   = '0;
                end
                else
                    token_char(c);
            end
            PH_LINE_START:
            begin
                // Slots full: the whole line is ignored.
                if (header_count < header_cap())
                begin
                    field_pos = '0;
                    if (c == CH_COLON)
                        parse_phase = PH_VAL_LEAD;
                    else
                    begin
                        parse_phase = PH_KEY;
                        key_char(c);
                    end
                end
            end
            PH_KEY:
            begin
                if (c == CH_COLON && field_pos > 0)
                begin
                    parse_phase = PH_VAL_LEAD;
                    field_pos   = '0;
                end
                else
                    key_char(c);
            end
            PH_VAL_LEAD:
            begin
                if (c != CH_SPACE)
                begin
                    parse_phase = PH_VALUE;
                    field_pos   = '0;
                    value_char(c);
                end
            end
            default:
                value_char(c);
        endcase
    endfunction

    // Work out every tagged character one accepted byte causes and queue them.
    function automatic void predict_byte(logic [7:0] c, logic eor);
        step_chars.delete();
        if (!text_done && bytes_examined < lim_request)
        begin
            scan_byte(c);
            if (!text_done)
            begin
                bytes_examined = bytes_examined + 10'd1;
                if (bytes_examined >= lim_request)
                begin
                    close_line();
                    text_done = 1'b1;
                end
            end
        end
        if (eor)
        begin
            if (!text_done)
                close_line();
            add_char(KIND_END, 4'd0, 8'd0, 8'd0, header_count);
            clear_parse();
        end
        if (step_chars.size() > 0)
            step_chars[step_chars.size() - 1].last_of_run = 1'b1;
        foreach (step_chars[i])
            expected_chars.push_back(step_chars[i]);
    endfunction

    function automatic void reset_model();
        lim_request = RST_REQUEST_LIMIT;
        lim_method  = RST_METHOD_LIMIT;
        lim_path    = RST_PATH_LIMIT;
        lim_version = RST_VERSION_LIMIT;
        lim_key     = RST_KEY_LIMIT;
        lim_value   = RST_VALUE_LIMIT;
        lim_headers = RST_HEADER_LIMIT;
        clear_parse();
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued bytes, with random gaps while gap_odds allows.
    // ------------------------------------------------------------------
    int unsigned send_gap;

    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        req_byte_t nxt;
        if (!rst_n)
        begin
            in_ch.valid          <= 1'b0;
            in_ch.in_byte        <= 8'd0;
            in_ch.end_of_request <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            // Predict on acceptance, with the limits in force right now.
            if (in_ch.valid && in_ch.ready)
            begin
                predict_byte(in_ch.in_byte, in_ch.end_of_request);
                bytes_accepted++;
                if (in_ch.end_of_request)
                    requests_done++;
            end
            // Hold the byte while the tokenizer stalls; otherwise pick the next move.
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_bytes.size() == 0)
                    in_ch.valid <= 1'b0;
                else if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0)
                begin
                    send_gap = $urandom_range(9, 0);
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    nxt = pending_bytes.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.in_byte        <= nxt.in_byte;
                    in_ch.end_of_request <= nxt.end_flag;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted character against the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    int unsigned stall_left;

    always @(posedge clk or negedge rst_n)
    begin : watch_chars
        hrt_res_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected result: kind %0d slot %0d position %0d char %0d",
                           out_ch.kind, out_ch.slot, out_ch.position, out_ch.char_out);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    check_field("kind", 8'(want.kind), 8'(out_ch.kind));
                    check_field("slot", 8'(want.slot), 8'(out_ch.slot));
                    check_field("position", want.position, out_ch.position);
                    check_field("char_out", want.char_out, out_ch.char_out);
                    check_field("headers_kept", 8'(want.headers_kept), 8'(out_ch.headers_kept));
                    check_field("last_of_run", 8'(want.last_of_run), 8'(out_ch.last_of_run));
                    chars_checked++;
                end
            end
            // Long hold-off first, then short random stalls.
            if (hold_cycles > 0)
                out_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0)
            begin
                stall_left = $urandom_range(9, 0);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Count the long receiver hold-off down in its own process.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Watchdog: give up if the run never drains.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_chars.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] c);
        req_byte_t b;
        b.in_byte  = c;
        b.end_flag = 1'b0;
        req_buf.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    // Mark the final byte as end of request and release the whole request
    // to the driver at once.
    function automatic void flush_request();
        req_buf[req_buf.size() - 1].end_flag = 1'b1;
        foreach (req_buf[i])
            pending_bytes.push_back(req_buf[i]);
        bytes_queued += req_buf.size();
        req_buf.delete();
    endfunction

    // Token or key character: never a separator, sometimes a high byte.
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(15, 0) == 0)
            return 8'($urandom_range(255, 128));
        c = 8'($urandom_range(126, 33));
        return (c == CH_COLON) ? "k" : c;
    endfunction

    function automatic logic [7:0] value_text();
        case ($urandom_range(7, 0))
            0: return CH_SPACE;
            1: return CH_COLON;
            default: return text_char();
        endcase
    endfunction

    // Anything at all, biased toward the bytes the parser reacts to.
    function automatic logic [7:0] noise_char();
        case ($urandom_range(9, 0))
            0: return CH_CR;
            1: return CH_LF;
            2: return CH_SPACE;
            3: return CH_COLON;
            4: return ($urandom_range(2, 0) == 0) ? CH_NUL : 8'($urandom_range(255, 0));
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic void end_line();
        case ($urandom_range(5, 0))
            0: add_byte(CH_LF);
            1: add_byte(CH_CR);
            2:
            begin
                // blank line in between
                add_byte(CH_CR);
                add_byte(CH_LF);
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
            default:
            begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        endcase
    endfunction

    // Mostly well-formed requests with random content; one in ten is noise.
    function automatic void queue_request();
        int unsigned n_tok;
        int unsigned n_hdr;
        int unsigned shape;
        shape = $urandom_range(9, 0);
        if (shape == 0)
            repeat ($urandom_range(12, 1)) add_byte(noise_char());
        else
        begin
            if ($urandom_range(3, 0) == 0)
                add_byte($urandom_range(1, 0) ? CH_CR : CH_LF);
            if ($urandom_range(5, 0) == 0)
                add_byte(CH_SPACE);
            n_tok = $urandom_range(4, 1);
            for (int t = 0; t < n_tok; t++)
            begin
                if (t > 0)
                    repeat ($urandom_range(2, 1)) add_byte(CH_SPACE);
                repeat ($urandom_range(5, 0)) add_byte(text_char());
            end
            end_line();
            n_hdr = $urandom_range(4, 0);
            for (int h = 0; h < n_hdr; h++)
            begin
                shape = $urandom_range(7, 0);
                if (shape == 0)
                    repeat ($urandom_range(4, 1)) add_byte(text_char());
                else
                begin
                    // shape 1 leaves the key empty
                    if (shape != 1)
                        repeat ($urandom_range(4, 1)) add_byte(text_char());
                    add_byte(CH_COLON);
                    repeat ($urandom_range(2, 0)) add_byte(CH_SPACE);
                    repeat ($urandom_range(5, 0)) add_byte(value_text());
                end
                if (h + 1 < n_hdr || $urandom_range(1, 0) == 0)
                    end_line();
            end
            // Sometimes end the text early with a zero byte and trail junk.
            if ($urandom_range(7, 0) == 0)
            begin
                add_byte(CH_NUL);
                repeat ($urandom_range(3, 0)) add_byte(noise_char());
            end
        end
        flush_request();
    endfunction

    task automatic fill_requests(int unsigned budget);
        int unsigned start;
        start = bytes_queued;
        while (bytes_queued - start < budget)
            queue_request();
    endtask

    // Wait until every byte went in and every result came out, then let the
    // pipeline settle for bytes that cause nothing.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || in_ch.valid || expected_chars.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(hrt_reg_t idx, logic [9:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_REQUEST_LIMIT: lim_request = value;
            REG_METHOD_LIMIT:  lim_method  = value[7:0];
            REG_PATH_LIMIT:    lim_path    = value[7:0];
            REG_VERSION_LIMIT: lim_version = value[7:0];
            REG_KEY_LIMIT:     lim_key     = value[7:0];
            REG_VALUE_LIMIT:   lim_value   = value[7:0];
            REG_HEADER_LIMIT:  lim_headers = value[3:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(logic [9:0] req, logic [7:0] meth, logic [7:0] path,
                              logic [7:0] ver, logic [7:0] key, logic [7:0] val,
                              logic [3:0] hdrs);
        write_limit(REG_REQUEST_LIMIT, req);
        write_limit(REG_METHOD_LIMIT, 10'(meth));
        write_limit(REG_PATH_LIMIT, 10'(path));
        write_limit(REG_VERSION_LIMIT, 10'(ver));
        write_limit(REG_KEY_LIMIT, 10'(key));
        write_limit(REG_VALUE_LIMIT, 10'(val));
        write_limit(REG_HEADER_LIMIT, 10'(hdrs));
        settings_used++;
    endtask

    function automatic logic [7:0] random_field_limit();
        case ($urandom_range(3, 0))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(6, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.in_byte        = 8'd0;
        in_ch.end_of_request = 1'b0;
        out_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = 3'd0;
        cfg_ch.data          = 10'd0;
        bytes_queued   = 0;
        bytes_accepted = 0;
        requests_done  = 0;
        chars_checked  = 0;
        settings_used  = 1;
        error_count    = 0;
        cycle_count    = 0;
        hold_cycles    = 0;
        gap_odds       = 0;
        reset_model();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed request on reset limits, no idling: leading line break,
        // four tokens (the last one dropped), a header with leading spaces and
        // a 0xFF byte, a line without colon, a colon with empty key, a zero
        // byte ending the text, and bytes ignored until end of request.
        add_byte(CH_LF);
        add_text("GE /p V1 x");
        add_byte(CH_CR);
        add_text("k: ");
        add_byte(8'hFF);
        add_text("v");
        add_byte(CH_LF);
        add_text("q");
        add_byte(CH_CR);
        add_byte(CH_COLON);
        add_byte(CH_NUL);
        add_text("zz");
        flush_request();
        wait_drained();

        // Tight limits: cut every field and fill the header slots quickly.
        set_limits(10'd1023, 8'd2, 8'd3, 8'd1, 8'd2, 8'd3, 4'd2);
        gap_odds = 4;
        fill_requests(90);
        wait_drained();

        // Nothing examined at all: only request end results.
        set_limits(10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
        gap_odds = 3;
        fill_requests(15);
        wait_drained();

        // Short byte budget, zero method, key and value limits, header limit above the cap.
        set_limits(10'd20, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 4'd15);
        gap_odds = 6;
        fill_requests(80);
        wait_drained();

        // Widest limits; block the receiver for a long stretch so the bundle
        // queue fills and the input stalls while bytes keep coming.
        set_limits(10'd1023, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 4'd15);
        gap_odds = 4;
        @(posedge clk);
        hold_cycles <= LONG_HOLD;
        fill_requests(100);
        wait_drained();

        // Random limits, and no idling for the last stretch.
        set_limits(($urandom_range(1, 0) == 0) ? 10'($urandom_range(40, 1)) : 10'd1023,
                   random_field_limit(), random_field_limit(), random_field_limit(),
                   random_field_limit(), random_field_limit(), 4'($urandom_range(15, 0)));
        gap_odds = 0;
        fill_requests(100);
        wait_drained();

        $display("Ran %0d request bytes in %0d requests under %0d limit settings,",
                 bytes_accepted, requests_done, settings_used);
        $display("checked %0d tagged characters field by field", chars_checked);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/hrt_pkg.sv
sv/hrt_ifs.sv
sv/hrt_front.sv
sv/hrt_queue.sv
sv/hrt_back.sv
sv/http_request_tokenizer_top.sv
sv/hrt_chk.sv
bench/testbench.sv
